@@ hdl/tga_rle_pixel_decoder_core_macros.svh @@
// Assertion macros shared by the TGA run-length decoder RTL.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication: whenever ante holds, cons holds too.
`define TGA_RLE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tga_rle: same-cycle check failed");
// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define TGA_RLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tga_rle: next-cycle check failed");
`else
`define TGA_RLE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TGA_RLE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/tga_rle_pkg.sv @@
// Types and constants shared by the TGA run-length decoder modules.
package tga_rle_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Header bytes above this value open a run packet.
    localparam logic [7:0] RUN_HEADER_BIAS = 8'd127;

    // Configuration as seen by the decoder.
    typedef struct packed {
        logic [2:0]  bytes_per_pixel;   // effective value, 1 to 4
        logic [31:0] pixel_total;       // image_width * image_height
    } cfg_t;

    // One decoded result.
    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic [31:0] first_index;
        logic [1:0]  status;
    } result_t;

endpackage

@@ hdl/tga_rle_cfg.sv @@
// Configuration registers and the precomputed image pixel total.
module tga_rle_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    output tga_rle_pkg::cfg_t   cfg
);

    logic [2:0]  bpp_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] total_reg;

    // The product is formed at write time so that the decoder sees a plain register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg    <= 3'd3;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            total_reg  <= 32'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tga_rle_pkg::REG_BYTES_PER_PIXEL: begin
                    bpp_reg <= cfg_wdata[2:0];
                end
                tga_rle_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata;
                    total_reg <= 32'(cfg_wdata) * 32'(height_reg);
                end
                tga_rle_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata;
                    total_reg  <= 32'(width_reg) * 32'(cfg_wdata);
                end
                default: begin
                end
            endcase
        end
    end

    // Zero acts as one byte, anything above four as four.
    always_comb begin
        if (bpp_reg == 3'd0) begin
            cfg.bytes_per_pixel = 3'd1;
        end else if (bpp_reg > 3'd4) begin
            cfg.bytes_per_pixel = 3'd4;
        end else begin
            cfg.bytes_per_pixel = bpp_reg;
        end
        cfg.pixel_total = total_reg;
    end

endmodule

@@ hdl/tga_rle_decode.sv @@
// Packet and pixel state of the decoder with its single-step update logic.
module tga_rle_decode (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [7:0]             stream_byte,
    input  logic                   start_of_image,
    input  tga_rle_pkg::cfg_t      cfg,
    output logic                   res_valid,
    output tga_rle_pkg::result_t   res,
    output logic                   halted
);

    logic        expecting_reg, expecting_next;
    logic        run_reg, run_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] done_reg, done_next;
    logic        halted_reg, halted_next;

    logic [31:0] gather_merged;
    logic [7:0]  reps;
    logic [32:0] after;

    always_comb begin
        expecting_next = expecting_reg;
        run_next       = run_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        gather_next    = gather_reg;
        done_next      = done_reg;
        halted_next    = halted_reg;
        res_valid      = 1'b0;
        res            = '0;
        gather_merged  = '0;
        reps           = 8'd1;
        after          = '0;

        if (start_of_image) begin
            halted_next    = 1'b0;
            expecting_next = 1'b1;
            run_next       = 1'b0;
            left_next      = 8'd0;
            pos_next       = 2'd0;
            gather_next    = 32'd0;
            done_next      = 32'd0;
        end

        if (!halted_next) begin
            if (expecting_next) begin
                // Packet header byte.
                run_next       = stream_byte[7];
                left_next      = stream_byte[7] ? (stream_byte - tga_rle_pkg::RUN_HEADER_BIAS)
                                                : (stream_byte + 8'd1);
                expecting_next = 1'b0;
                pos_next       = 2'd0;
                gather_next    = 32'd0;
            end else begin
                gather_merged = gather_next | ({24'd0, stream_byte} << {pos_next, 3'b000});
                if (({1'b0, pos_next} + 3'd1) < cfg.bytes_per_pixel) begin
                    pos_next    = pos_next + 2'd1;
                    gather_next = gather_merged;
                end else begin
                    // Pixel complete.
                    reps             = run_next ? left_next : 8'd1;
                    after            = {1'b0, done_next} + {25'd0, reps};
                    res_valid        = 1'b1;
                    res.pixel_value  = gather_merged;
                    res.repeat_count = reps;
                    res.first_index  = done_next;
                    pos_next         = 2'd0;
                    gather_next      = 32'd0;
                    if (after > {1'b0, cfg.pixel_total}) begin
                        res.status  = tga_rle_pkg::STATUS_OVERFLOW;
                        halted_next = 1'b1;
                    end else begin
                        done_next  = after[31:0];
                        left_next  = left_next - reps;
                        res.status = tga_rle_pkg::STATUS_OK;
                        if (left_next == 8'd0) begin
                            expecting_next = 1'b1;
                            if (done_next >= cfg.pixel_total) begin
                                res.status  = tga_rle_pkg::STATUS_COMPLETE;
                                halted_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expecting_reg <= 1'b1;
            run_reg       <= 1'b0;
            left_reg      <= 8'd0;
            pos_reg       <= 2'd0;
            gather_reg    <= 32'd0;
            done_reg      <= 32'd0;
            halted_reg    <= 1'b0;
        end else if (step_en) begin
            expecting_reg <= expecting_next;
            run_reg       <= run_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            gather_reg    <= gather_next;
            done_reg      <= done_next;
            halted_reg    <= halted_next;
        end
    end

    assign halted = halted_reg;

endmodule

@@ hdl/tga_rle_pixel_decoder_core.sv @@
// Top level of the TGA run-length pixel decoder: handshake registers and assertions.
//
// Usage: coded TGA pixel data enters one byte per request on the s_ channel;
// s_tuser marks the first byte of an image, which must be a packet header and
// clears all counters. Header bytes and all but the last byte of a pixel
// produce nothing. Each completed pixel leaves on the m_ channel with its
// repeat count, its linear index and a status code (ok, image complete, or
// too many pixels). After completion or overflow, bytes are dropped until the
// next start-of-image request.
// Timing: an accepted byte is registered in the input register and then decoded
// into the output register, which drives m_tvalid; a stall can hold the byte in
// the input register. One byte per cycle is sustained while m_tready is high;
// the packet and pixel state is a single register set updated once per byte.
// Stalls: while a result waits with m_tready low, a byte in the input register
// is held undecoded and s_tready drops, whether or not that byte would produce
// a result; s_tready follows m_tready in the same cycle. Bytes are never lost.
// Reset (aresetn low, synchronous) empties both registers, selects three bytes
// per pixel and a 1x1 image. Configuration is written through cfg_wr_en /
// cfg_index / cfg_wdata while no request is in flight.
`include "tga_rle_pixel_decoder_core_macros.svh"

module tga_rle_pixel_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Coded byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  logic [0:0]  s_tuser,   // [0] start_of_image
    // Decoded pixels.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] pixel_value, [39:32] repeat_count,
                                   // [71:40] first_index
    output logic [1:0]  m_tuser    // [1:0] status
);

    tga_rle_pkg::cfg_t    cfg;
    tga_rle_pkg::result_t res;
    logic                 res_valid;
    logic                 halted;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_sof_reg;

    // Output register.
    logic                 out_valid_reg;
    tga_rle_pkg::result_t out_res_reg;

    // A byte is decoded when the output register is empty or being emptied.
    logic step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    tga_rle_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tga_rle_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step),
        .stream_byte    (in_byte_reg),
        .start_of_image (in_sof_reg),
        .cfg            (cfg),
        .res_valid      (res_valid),
        .res            (res),
        .halted         (halted)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_sof_reg  <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.first_index, out_res_reg.repeat_count,
                       out_res_reg.pixel_value};
    assign m_tuser  = out_res_reg.status;

    // A completing or overflowing pixel must leave the decoder halted.
    `TGA_RLE_ASSERT_NEXT(a_halt_after_end, aclk, aresetn,
        step && res_valid && res.status != tga_rle_pkg::STATUS_OK, halted)
    // Only the three defined status codes ever leave the block.
    `TGA_RLE_ASSERT_IMP(a_status_code, aclk, aresetn,
        m_tvalid, m_tuser == tga_rle_pkg::STATUS_OK || m_tuser == tga_rle_pkg::STATUS_COMPLETE ||
        m_tuser == tga_rle_pkg::STATUS_OVERFLOW)
    // Every emitted pixel covers at least one position.
    `TGA_RLE_ASSERT_IMP(a_repeat_nonzero, aclk, aresetn,
        m_tvalid, m_tdata[39:32] != 8'd0)

endmodule
